// File: rtl/core/brct_pkg.sv
// brct_pkg: shared types, codes and sizes of the block reference count table.
// No dependencies; imported by brct_front, brct_back and the top level.
package brct_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W  = $clog2(ENTRIES + 1);
  localparam int MAX_OUT = 16;

  localparam logic [1:0] CMD_CHECK = 2'd0;
  localparam logic [1:0] CMD_SCAN  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_NONE = 2'd2;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    KIND_CHECK,
    KIND_SCAN,
    KIND_NONE,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] blk;
    logic [39:0] size;
    logic [4:0]  want;
  } item_t;

  typedef struct packed {
    logic [31:0] blk;
    logic [39:0] size;
    logic [7:0]  count;
  } slot_t;

  typedef struct packed {
    logic        strobe;
    logic [3:0]  index;
    logic [31:0] blk;
    logic [39:0] size;
    logic [7:0]  count;
    logic [1:0]  status;
    logic        last;
  } result_t;

endpackage

// File: rtl/core/brct_front.sv
// brct_front: takes commands, classifies them and holds them in a two-entry queue.
// Depends on brct_pkg.
module brct_front import brct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_block_addr,
  input  logic [39:0] in_file_size,
  input  logic [4:0]  in_max_matches,
  output logic        q_vld,
  output item_t       q_item,
  input  logic        q_pop
);

  logic [1:0] cnt_r, cnt_nxt;
  logic       head_r, head_nxt;
  item_t      ent_r [2];
  item_t      item_in;
  logic       push;
  logic       tail;
  logic [4:0] want;

  always_comb begin
    want = (in_max_matches > 5'(MAX_OUT)) ? 5'(MAX_OUT) : in_max_matches;
    item_in.blk  = in_block_addr;
    item_in.size = in_file_size;
    item_in.want = want;
    unique case (in_command)
      CMD_CHECK: item_in.kind = KIND_CHECK;
      CMD_SCAN:  item_in.kind = (want == 5'd0) ? KIND_NONE : KIND_SCAN;
      CMD_CLEAR: item_in.kind = KIND_CLEAR;
      default:   item_in.kind = KIND_CHECK;
    endcase
  end

  assign busy   = (cnt_r == 2'd2);
  assign push   = start && !busy && (in_command != CMD_RSVD);
  assign tail   = head_r ^ cnt_r[0];
  assign q_vld  = (cnt_r != 2'd0);
  assign q_item = ent_r[head_r];

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    if (q_pop && q_vld) begin
      head_nxt = ~head_r;
    end
    case ({push, q_pop && q_vld})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      head_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[tail] <= item_in;
    end
  end

endmodule

// File: rtl/core/brct_back.sv
// brct_back: slot memory and the sequencer that walks it for check, scan and clear.
// Depends on brct_pkg; fed by brct_front.
module brct_back import brct_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_vld,
  input  item_t   q_item,
  output logic    q_pop,
  output result_t res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_END
  } state_t;

  state_t            state_r, state_nxt;
  item_t             cur_r, cur_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  slot_t             pend_slot_r, pend_slot_nxt;
  logic [4:0]        nmatch_r, nmatch_nxt;
  result_t           res_r, res_nxt;

  slot_t             mem [ENTRIES];
  slot_t             rd_data_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  slot_t             wr_data;

  logic              hit_blk, hit_key, at_end, stop;

  assign hit_blk = (rd_data_r.blk == cur_r.blk);
  assign hit_key = hit_blk && (rd_data_r.size == cur_r.size);
  assign at_end  = (FILL_W'(cmp_idx_r) == fill_r - FILL_W'(1));
  assign res     = res_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    fill_nxt      = fill_r;
    rd_idx_nxt    = rd_idx_r;
    pend_vld_nxt  = pend_vld_r;
    pend_idx_nxt  = pend_idx_r;
    pend_slot_nxt = pend_slot_r;
    nmatch_nxt    = nmatch_r;
    res_nxt       = '0;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = rd_idx_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = cmp_idx_r;
    wr_data       = rd_data_r;
    stop          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_vld) begin
          q_pop   = 1'b1;
          cur_nxt = q_item;
          unique case (q_item.kind)
            KIND_CLEAR: begin
              fill_nxt       = '0;
              res_nxt.strobe = 1'b1;
              res_nxt.status = STAT_OK;
              res_nxt.last   = 1'b1;
            end
            KIND_NONE: begin
              res_nxt.strobe = 1'b1;
              res_nxt.status = STAT_NONE;
              res_nxt.last   = 1'b1;
            end
            default: begin
              nmatch_nxt   = 5'd0;
              pend_vld_nxt = 1'b0;
              if (fill_r == '0) begin
                state_nxt = S_END;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                rd_idx_nxt = FILL_W'(1);
                state_nxt  = S_RUN;
              end
            end
          endcase
        end
      end
      S_RUN: begin
        if (cmp_vld_r) begin
          if (cur_r.kind == KIND_CHECK) begin
            if (hit_key) begin
              wr_en         = 1'b1;
              wr_data.count = (rd_data_r.count == COUNT_MAX) ? COUNT_MAX
                                                             : rd_data_r.count + 8'd1;
              res_nxt.strobe = 1'b1;
              res_nxt.index  = 4'(cmp_idx_r);
              res_nxt.blk    = rd_data_r.blk;
              res_nxt.size   = rd_data_r.size;
              res_nxt.count  = wr_data.count;
              res_nxt.status = STAT_OK;
              res_nxt.last   = 1'b1;
              state_nxt      = S_IDLE;
              stop           = 1'b1;
            end else if (at_end) begin
              state_nxt = S_END;
              stop      = 1'b1;
            end
          end else begin
            if (hit_blk) begin
              if (pend_vld_r) begin
                res_nxt.strobe = 1'b1;
                res_nxt.index  = 4'(pend_idx_r);
                res_nxt.blk    = pend_slot_r.blk;
                res_nxt.size   = pend_slot_r.size;
                res_nxt.count  = pend_slot_r.count;
                res_nxt.status = STAT_OK;
              end
              pend_vld_nxt  = 1'b1;
              pend_idx_nxt  = cmp_idx_r;
              pend_slot_nxt = rd_data_r;
              nmatch_nxt    = nmatch_r + 5'd1;
              if (nmatch_r + 5'd1 == cur_r.want) begin
                state_nxt = S_END;
                stop      = 1'b1;
              end
            end
            if (at_end) begin
              state_nxt = S_END;
              stop      = 1'b1;
            end
          end
        end
        if (!stop && (rd_idx_r < fill_r)) begin
          rd_en      = 1'b1;
          rd_idx_nxt = rd_idx_r + FILL_W'(1);
        end
      end
      S_END: begin
        state_nxt      = S_IDLE;
        res_nxt.strobe = 1'b1;
        res_nxt.last   = 1'b1;
        if (cur_r.kind == KIND_CHECK) begin
          if (fill_r == FILL_W'(ENTRIES)) begin
            res_nxt.status = STAT_FULL;
          end else begin
            wr_en          = 1'b1;
            wr_addr        = fill_r[IDX_W-1:0];
            wr_data.blk    = cur_r.blk;
            wr_data.size   = cur_r.size;
            wr_data.count  = 8'd1;
            fill_nxt       = fill_r + FILL_W'(1);
            res_nxt.index  = 4'(fill_r);
            res_nxt.blk    = cur_r.blk;
            res_nxt.size   = cur_r.size;
            res_nxt.count  = 8'd1;
            res_nxt.status = STAT_OK;
          end
        end else if (pend_vld_r) begin
          res_nxt.index  = 4'(pend_idx_r);
          res_nxt.blk    = pend_slot_r.blk;
          res_nxt.size   = pend_slot_r.size;
          res_nxt.count  = pend_slot_r.count;
          res_nxt.status = STAT_OK;
        end else begin
          res_nxt.status = STAT_NONE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      cmp_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      res_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      cmp_vld_r  <= rd_en;
      pend_vld_r <= pend_vld_nxt;
      res_r      <= res_nxt;
    end
    cur_r       <= cur_nxt;
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= rd_addr;
    pend_idx_r  <= pend_idx_nxt;
    pend_slot_r <= pend_slot_nxt;
    nmatch_r    <= nmatch_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/block_reference_count_table_top.sv
// block_reference_count_table_top: top level of the block reference count table.
// Depends on brct_pkg, brct_front and brct_back.
//
// Command channel: a command is transferred at a rising edge with start high and
// busy low. Check (0) finds or appends a (block address, file size) slot and bumps
// its count; scan (1) returns up to max_matches slots with the given address in
// insertion order; clear (2) empties the table. Code 3 is taken and dropped.
// Result channel: each result is on the out_ ports for one cycle with out_strobe
// high; out_is_last marks the final result of a command. The receiver cannot
// stall, so results are never held.
// A two-entry command queue sits in front of the sequencer; busy is high while
// it is full. The sequencer reads one slot per cycle from the slot memory, in
// slot order: a check stops at the first slot with its address and size, a
// scan at max_matches matches or after the last filled slot. Clear and a scan
// with max_matches zero are answered from the idle state without a read. The
// sequencer takes the next queued command only after the current one has given
// its last result, while the queue can still take commands behind it.
// Synchronous reset empties the table and the queue; no clearing pass is needed.
module block_reference_count_table_top import brct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_block_addr,
  input  logic [39:0] in_file_size,
  input  logic [4:0]  in_max_matches,
  output logic        out_strobe,
  output logic [3:0]  out_entry_index,
  output logic [31:0] out_entry_block,
  output logic [39:0] out_entry_size,
  output logic [7:0]  out_ref_count,
  output logic [1:0]  out_status,
  output logic        out_is_last
);

  logic    q_vld;
  item_t   q_item;
  logic    q_pop;
  result_t res;

  brct_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_block_addr  (in_block_addr),
    .in_file_size   (in_file_size),
    .in_max_matches (in_max_matches),
    .q_vld          (q_vld),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  brct_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_vld  (q_vld),
    .q_item (q_item),
    .q_pop  (q_pop),
    .res    (res)
  );

  assign out_strobe      = res.strobe;
  assign out_entry_index = res.index;
  assign out_entry_block = res.blk;
  assign out_entry_size  = res.size;
  assign out_ref_count   = res.count;
  assign out_status      = res.status;
  assign out_is_last     = res.last;

endmodule
